### hw/rtl/rlpm_pkg.sv
// Package for the run-length pattern match counter.
// Holds sizes, command codes and the run record type; no dependencies.
package rlpm_pkg;
    localparam int MAX_PATTERN_RUNS = 1024;
    localparam int LENGTH_BITS      = 48;
    localparam int IDX_BITS         = $clog2(MAX_PATTERN_RUNS);
    localparam int CNT_BITS         = IDX_BITS + 1;
    localparam int COUNT_BITS       = 48;
    localparam int RUN_BITS         = LENGTH_BITS + 5;

    localparam logic [LENGTH_BITS-1:0] LEN_MAX   = '1;
    localparam logic [COUNT_BITS-1:0]  COUNT_MAX = '1;

    typedef enum logic [1:0] {
        CMD_PAT_RUN  = 2'd0,
        CMD_PAT_END  = 2'd1,
        CMD_TEXT_RUN = 2'd2,
        CMD_TEXT_END = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [LENGTH_BITS-1:0] len;
        logic [4:0]             ch;
    } t_run;
endpackage

### hw/rtl/rlpm_ram.sv
// Generic single-port-write, single-read synchronous RAM with registered read.
// No dependencies.
module rlpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### hw/rtl/run_length_pattern_match_counter.sv
// Top level of the run-length pattern match counter.
// Uses rlpm_pkg and three rlpm_ram instances (pattern, failure links, text history).
// Pattern run: read the last stored run, then merge into it or append. Pattern end:
// with three or more runs, build the failure table, following failure links. Text
// run: merged when the letter repeats, else a commit with failure-link steps. Text end:
// commit, then one result held in an output register until taken.
// Reset (synchronous, active low) clears all control state; RAMs are not cleared.
module run_length_pattern_match_counter (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [1:0]                   i_command,
    input  logic [19:0]                  i_run_length,
    input  logic [4:0]                   i_run_char,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [rlpm_pkg::COUNT_BITS-1:0] o_match_count,
    output logic                         o_count_saturated,
    output logic                         o_pattern_overflow
);
    import rlpm_pkg::*;

    typedef enum logic [15:0] {
        S_IDLE  = 16'h0001,
        S_PRD   = 16'h0002, // pattern last entry read
        S_PWR   = 16'h0004,
        S_BINIT = 16'h0008,
        S_BRDI  = 16'h0010, // read p[i+1]
        S_BRDJ  = 16'h0020, // read p[j+1]
        S_BCMP  = 16'h0040,
        S_BFL   = 16'h0080, // failure read wait
        S_CRD   = 16'h0100, // commit: read first pattern run, then last in S_CRD2
        S_CRD2  = 16'h0200,
        S_CRD3  = 16'h0400,
        S_KRD   = 16'h0800, // read p[j+1]
        S_KCMP  = 16'h1000,
        S_KFL   = 16'h2000,
        S_KHIST = 16'h4000,
        S_OUT   = 16'h8000
    } t_state;

    t_state r_state;
    logic r_phase, r_ovf, r_pend_v, r_end_chk, r_after_end;
    logic [CNT_BITS-1:0] r_m, r_trc;
    logic [IDX_BITS-1:0] r_head, r_i, r_j;
    t_run r_pend, r_cur, r_in, r_pi, r_p0;
    logic [COUNT_BITS-1:0] r_occ;
    logic r_first;
    t_run r_prev;

    // RAM ports
    logic p_we; logic [IDX_BITS-1:0] p_wa, p_ra; t_run p_wd, p_rd;
    logic f_we; logic [IDX_BITS-1:0] f_wa, f_ra; logic [CNT_BITS-1:0] f_wd, f_rd;
    logic h_we; logic [IDX_BITS-1:0] h_wa, h_ra; t_run h_wd, h_rd;

    rlpm_ram #(.WIDTH(RUN_BITS), .DEPTH(MAX_PATTERN_RUNS)) u_pat (
        .i_clk, .i_we(p_we), .i_waddr(p_wa), .i_wdata(p_wd), .i_raddr(p_ra), .o_rdata(p_rd));
    rlpm_ram #(.WIDTH(CNT_BITS), .DEPTH(MAX_PATTERN_RUNS)) u_fail (
        .i_clk, .i_we(f_we), .i_waddr(f_wa), .i_wdata(f_wd), .i_raddr(f_ra), .o_rdata(f_rd));
    rlpm_ram #(.WIDTH(RUN_BITS), .DEPTH(MAX_PATTERN_RUNS)) u_hist (
        .i_clk, .i_we(h_we), .i_waddr(h_wa), .i_wdata(h_wd), .i_raddr(h_ra), .o_rdata(h_rd));

    logic acc;
    assign o_stall = (r_state != S_IDLE);
    assign acc = i_valid && !o_stall;
    assign o_valid = (r_state == S_OUT);

    function automatic logic [LENGTH_BITS-1:0] len_add(input logic [LENGTH_BITS-1:0] a,
                                                        input logic [LENGTH_BITS-1:0] b);
        logic [LENGTH_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[LENGTH_BITS] ? LEN_MAX : s[LENGTH_BITS-1:0];
    endfunction

    function automatic logic [COUNT_BITS-1:0] count_add(input logic [COUNT_BITS-1:0] a,
                                                         input logic [COUNT_BITS-1:0] b);
        logic [COUNT_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COUNT_BITS] ? COUNT_MAX : s[COUNT_BITS-1:0];
    endfunction

    function automatic logic covers(input t_run p, input t_run t);
        return p.ch == t.ch && p.len <= t.len;
    endfunction

    logic [IDX_BITS-1:0] k_idx, m_last;
    assign k_idx  = IDX_BITS'(r_m - CNT_BITS'(2));
    assign m_last = IDX_BITS'(r_m - CNT_BITS'(1));

    t_run in_run;
    assign in_run.len = LENGTH_BITS'(i_run_length);
    assign in_run.ch  = i_run_char;

    always_comb begin
        p_we = 1'b0; p_wa = r_i; p_wd = r_in; p_ra = r_i;
        f_we = 1'b0; f_wa = r_i; f_wd = '0; f_ra = r_j;
        h_we = 1'b0; h_wa = r_head; h_wd = r_cur; h_ra = r_head;
        unique case (r_state)
            S_IDLE:  p_ra = m_last;
            S_PWR:   begin
                p_we = 1'b1;
                p_wa = r_i;
                p_wd = r_in;
            end
            S_BINIT: begin
                f_we = 1'b1; f_wa = IDX_BITS'(1); f_wd = '0;
            end
            S_BRDI:  p_ra = r_i + IDX_BITS'(1);
            S_BRDJ:  p_ra = r_j + IDX_BITS'(1);
            S_BCMP:  f_ra = r_j;
            // refetch p[i+1] so that it is back on the read port in S_BRDJ
            S_BFL:   p_ra = r_i + IDX_BITS'(1);
            S_CRD:   p_ra = '0;
            S_CRD2:  p_ra = m_last;
            S_KRD:   p_ra = r_j + IDX_BITS'(1);
            S_KCMP:  begin
                // on a hit fetch the link of a full match and the run before it
                f_ra = (p_rd == r_cur) ? k_idx : r_j;
                h_ra = r_head - k_idx;
            end
            default: ;
        endcase
        if (r_state == S_BCMP) begin
            if (!(r_j != '0 && p_rd != r_pi)) begin
                f_we = 1'b1;
                f_wa = r_i + IDX_BITS'(1);
                f_wd = CNT_BITS'(r_j) + ((p_rd == r_pi) ? CNT_BITS'(1) : CNT_BITS'(0));
            end
        end
        if (r_state == S_CRD) begin
            h_we = 1'b1;
            h_wa = r_first ? '0 : r_head + IDX_BITS'(1);
            h_wd = r_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_phase <= 1'b0; r_ovf <= 1'b0; r_pend_v <= 1'b0;
            r_end_chk <= 1'b0; r_m <= '0; r_trc <= '0; r_head <= '0; r_j <= '0;
            r_occ <= '0; r_after_end <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: if (acc) begin
                    r_in <= in_run;
                    unique case (t_cmd'(i_command))
                        CMD_PAT_RUN:
                            if (!r_phase && i_run_length != '0 && !r_ovf)
                                r_state <= S_PRD;
                        CMD_PAT_END:
                            if (!r_phase) begin
                                r_phase <= 1'b1;
                                if (!r_ovf && r_m >= CNT_BITS'(3)) r_state <= S_BINIT;
                            end
                        CMD_TEXT_RUN:
                            if (r_phase && i_run_length != '0) begin
                                if (r_pend_v && r_pend.ch == i_run_char)
                                    r_pend.len <= len_add(r_pend.len, in_run.len);
                                else begin
                                    r_pend <= in_run; r_pend_v <= 1'b1;
                                    if (r_pend_v) begin
                                        r_cur <= r_pend; r_after_end <= 1'b0;
                                        r_first <= (r_trc == '0);
                                        r_state <= S_CRD;
                                    end
                                end
                            end
                        CMD_TEXT_END:
                            if (r_phase && r_pend_v) begin
                                r_cur <= r_pend; r_after_end <= 1'b1;
                                r_first <= (r_trc == '0);
                                r_state <= S_CRD;
                            end else r_state <= S_OUT;
                        default: ;
                    endcase
                end
                S_PRD: begin
                    // p_rd holds the last stored run
                    if (r_m != '0 && p_rd.ch == r_in.ch) begin
                        r_i <= m_last; r_in <= '{len: len_add(p_rd.len, r_in.len), ch: r_in.ch};
                        r_state <= S_PWR;
                    end else if (r_m < CNT_BITS'(MAX_PATTERN_RUNS)) begin
                        r_i <= IDX_BITS'(r_m); r_m <= r_m + CNT_BITS'(1);
                        r_state <= S_PWR;
                    end else begin
                        r_ovf <= 1'b1; r_state <= S_IDLE;
                    end
                end
                S_PWR: r_state <= S_IDLE;
                S_BINIT: begin
                    r_i <= IDX_BITS'(1); r_j <= '0;
                    r_state <= (k_idx > IDX_BITS'(1)) ? S_BRDI : S_IDLE;
                end
                S_BRDI: r_state <= S_BRDJ;
                S_BRDJ: begin r_pi <= p_rd; r_state <= S_BCMP; end
                S_BCMP: begin
                    if (r_j != '0 && p_rd != r_pi) r_state <= S_BFL;
                    else begin
                        r_i <= r_i + IDX_BITS'(1);
                        if (r_i + IDX_BITS'(1) < k_idx) begin
                            if (p_rd == r_pi) r_j <= r_j + IDX_BITS'(1);
                            r_state <= S_BRDI;
                        end else begin
                            // text matching starts from an empty match
                            r_j <= '0;
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_BFL: begin r_j <= IDX_BITS'(f_rd); r_state <= S_BRDJ; end
                S_CRD: begin
                    r_prev <= h_rd;
                    // prev run comes from old head; read it before the write lands
                    r_head <= r_first ? '0 : r_head + IDX_BITS'(1);
                    if (r_trc < CNT_BITS'(MAX_PATTERN_RUNS)) r_trc <= r_trc + CNT_BITS'(1);
                    r_state <= S_CRD2;
                end
                S_CRD2: begin r_p0 <= p_rd; r_state <= S_CRD3; end
                S_CRD3: begin
                    if (!r_ovf && r_m == CNT_BITS'(1)) begin
                        if (covers(r_p0, r_cur))
                            r_occ <= count_add(r_occ, COUNT_BITS'(r_cur.len - r_p0.len)
                                                      + COUNT_BITS'(1));
                    end else if (!r_ovf && r_m == CNT_BITS'(2)) begin
                        if (!r_first && covers(r_p0, r_prev) && covers(p_rd, r_cur))
                            r_occ <= count_add(r_occ, COUNT_BITS'(1));
                    end else if (!r_ovf && r_m >= CNT_BITS'(3)) begin
                        if (r_end_chk) begin
                            if (covers(p_rd, r_cur))
                                r_occ <= count_add(r_occ, COUNT_BITS'(1));
                            r_end_chk <= 1'b0;
                        end
                    end
                    if (!r_ovf && r_m >= CNT_BITS'(3) && !r_first) r_state <= S_KRD;
                    else r_state <= r_after_end ? S_OUT : S_IDLE;
                end
                S_KRD: r_state <= S_KCMP;
                S_KCMP: begin
                    if (r_j != '0 && p_rd != r_cur) r_state <= S_KFL;
                    else begin
                        if (IDX_BITS'(r_j + ((p_rd == r_cur) ? 1 : 0)) == k_idx
                            && p_rd == r_cur) begin
                            r_j <= k_idx;
                            r_state <= S_KHIST;
                        end else begin
                            if (p_rd == r_cur) r_j <= r_j + IDX_BITS'(1);
                            r_state <= r_after_end ? S_OUT : S_IDLE;
                        end
                    end
                end
                S_KFL: begin r_j <= IDX_BITS'(f_rd); r_state <= S_KRD; end
                S_KHIST: begin
                    // h_rd holds the run before the match, f_rd the link of a full match
                    if (covers(r_p0, h_rd)) r_end_chk <= 1'b1;
                    r_j <= IDX_BITS'(f_rd);
                    r_state <= r_after_end ? S_OUT : S_IDLE;
                end
                S_OUT: if (!i_stall) begin
                    r_state <= S_IDLE; r_phase <= 1'b0; r_ovf <= 1'b0; r_pend_v <= 1'b0;
                    r_end_chk <= 1'b0; r_m <= '0; r_trc <= '0; r_head <= '0; r_j <= '0;
                    r_occ <= '0;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_match_count      = r_ovf ? '0 : r_occ;
    assign o_count_saturated  = !r_ovf && (r_occ == COUNT_MAX);
    assign o_pattern_overflow = r_ovf;

    assert property (@(posedge i_clk) disable iff (!i_rst_n) o_valid |-> o_stall)
        else $error("result shown while accepting");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_m <= CNT_BITS'(MAX_PATTERN_RUNS))
        else $error("pattern count past store");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_match_count)))
        else $error("held result changed");
endmodule

### sim/run_length_pattern_match_counter_tb.sv
// Testbench for the run-length pattern match counter.
// Depends on rlpm_pkg and run_length_pattern_match_counter; it carries its own
// model of the matcher and checks every count that the block reports.
module run_length_pattern_match_counter_tb;
    import rlpm_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int TARGET_ITEMS = 1850;
    localparam int HOLD_CYCLES  = 400;

    typedef struct {
        t_cmd        cmd;
        logic [19:0] len;
        logic [4:0]  ch;
    } t_item;

    typedef struct {
        logic [COUNT_BITS-1:0] count;
        logic                  sat;
        logic                  ovf;
    } t_count;

    typedef struct {
        t_cmd        cmd;
        logic [19:0] len;
        logic [4:0]  ch;
        bit          typed;
        t_count      want;
    } t_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    logic [1:0]            i_command;
    logic [19:0]           i_run_length;
    logic [4:0]            i_run_char;
    logic                  o_valid;
    logic                  i_stall;
    logic [COUNT_BITS-1:0] o_match_count;
    logic                  o_count_saturated;
    logic                  o_pattern_overflow;

    run_length_pattern_match_counter i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_command          (i_command),
        .i_run_length       (i_run_length),
        .i_run_char         (i_run_char),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_match_count      (o_match_count),
        .o_count_saturated  (o_count_saturated),
        .o_pattern_overflow (o_pattern_overflow)
    );

    // ---------------- matcher model ----------------
    t_run   pat_runs [MAX_PATTERN_RUNS];
    int     fail_link [MAX_PATTERN_RUNS];
    t_run   text_ring [MAX_PATTERN_RUNS];
    int     pat_cnt, ring_head, text_cnt, kmp_pos;
    bit     pat_ovf, tail_pending, open_valid, in_text;
    t_run   open_run;
    logic [COUNT_BITS-1:0] occ_count;

    t_count count_q [$];
    t_item  stim_q [$];
    int     err_cnt, n_items, n_counts, n_ovf, n_nonzero, cycles;
    bit     idle_off, hold_req;

    function automatic bit run_eq(t_run a, t_run b);
        return a.ch == b.ch && a.len == b.len;
    endfunction

    function automatic bit run_covers(t_run p, t_run t);
        return p.ch == t.ch && p.len <= t.len;
    endfunction

    function automatic logic [LENGTH_BITS-1:0] sat_len(logic [LENGTH_BITS-1:0] a,
                                                       logic [LENGTH_BITS-1:0] b);
        logic [LENGTH_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[LENGTH_BITS] ? LEN_MAX : s[LENGTH_BITS-1:0];
    endfunction

    function automatic void bump_count(logic [LENGTH_BITS-1:0] v);
        logic [COUNT_BITS+LENGTH_BITS:0] s;
        s = occ_count + v;
        occ_count = (s > COUNT_MAX) ? COUNT_MAX : s[COUNT_BITS-1:0];
    endfunction

    function automatic void clear_matcher();
        foreach (pat_runs[i]) begin
            pat_runs[i] = '0;
            text_ring[i] = '0;
            fail_link[i] = 0;
        end
        pat_cnt = 0; ring_head = 0; text_cnt = 0; kmp_pos = 0;
        pat_ovf = 0; tail_pending = 0; open_valid = 0; in_text = 0;
        open_run = '0; occ_count = '0;
    endfunction

    function automatic void build_links(int k);
        int j;
        j = 0;
        fail_link[1] = 0;
        for (int i = 1; i < k; i++) begin
            while (j > 0 && !run_eq(pat_runs[j+1], pat_runs[i+1]))
                j = fail_link[j];
            if (run_eq(pat_runs[j+1], pat_runs[i+1]))
                j++;
            fail_link[i+1] = j;
        end
    endfunction

    function automatic void close_text_run(t_run r);
        bit   first;
        t_run prev;
        int   head, k, j, li;
        first = (text_cnt == 0);
        prev  = text_ring[ring_head];
        head  = first ? 0 : (ring_head + 1) % MAX_PATTERN_RUNS;
        ring_head = head;
        text_ring[head] = r;
        if (text_cnt < MAX_PATTERN_RUNS) text_cnt++;
        if (pat_ovf || pat_cnt == 0) return;
        if (pat_cnt == 1) begin
            if (run_covers(pat_runs[0], r))
                bump_count(r.len - pat_runs[0].len + 1);
        end else if (pat_cnt == 2) begin
            if (!first && run_covers(pat_runs[0], prev) && run_covers(pat_runs[1], r))
                bump_count(1);
        end else begin
            k = pat_cnt - 2;
            j = kmp_pos;
            if (tail_pending) begin
                if (run_covers(pat_runs[pat_cnt-1], r)) bump_count(1);
                tail_pending = 0;
            end
            if (!first) begin
                while (j > 0 && !run_eq(pat_runs[j+1], r))
                    j = fail_link[j];
                if (run_eq(pat_runs[j+1], r))
                    j++;
                if (j == k) begin
                    li = (head + MAX_PATTERN_RUNS - k) % MAX_PATTERN_RUNS;
                    if (run_covers(pat_runs[0], text_ring[li])) tail_pending = 1;
                    j = fail_link[k];
                end
                kmp_pos = j;
            end
        end
    endfunction

    // Advance the model by one transfer; returns 1 when a count is due.
    function automatic bit predict_count(t_item it, output t_count res);
        t_run r;
        r.len = LENGTH_BITS'(it.len);
        r.ch  = it.ch;
        res   = '{default: '0};
        case (it.cmd)
            CMD_PAT_RUN: begin
                if (!in_text && it.len != 0 && !pat_ovf) begin
                    if (pat_cnt > 0 && pat_runs[pat_cnt-1].ch == r.ch)
                        pat_runs[pat_cnt-1].len = sat_len(pat_runs[pat_cnt-1].len, r.len);
                    else if (pat_cnt < MAX_PATTERN_RUNS)
                        pat_runs[pat_cnt++] = r;
                    else
                        pat_ovf = 1;
                end
                return 0;
            end
            CMD_PAT_END: begin
                if (!in_text) begin
                    if (!pat_ovf && pat_cnt >= 3) build_links(pat_cnt - 2);
                    in_text = 1;
                end
                return 0;
            end
            CMD_TEXT_RUN: begin
                if (in_text && it.len != 0) begin
                    if (open_valid && open_run.ch == r.ch) begin
                        open_run.len = sat_len(open_run.len, r.len);
                    end else begin
                        if (open_valid) close_text_run(open_run);
                        open_run   = r;
                        open_valid = 1;
                    end
                end
                return 0;
            end
            default: begin
                if (in_text && open_valid) close_text_run(open_run);
                res.count = pat_ovf ? '0 : occ_count;
                res.sat   = !pat_ovf && occ_count == COUNT_MAX;
                res.ovf   = pat_ovf;
                clear_matcher();
                return 1;
            end
        endcase
    endfunction

    // ---------------- clock, reset, watchdog ----------------
    always begin
        i_clk = 1'b1; #4;
        i_clk = 1'b0; #4;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // No idling in a long window in the middle of the run.
    function automatic bit want_idle();
        return !idle_off && $urandom_range(99) < 30;
    endfunction

    // ---------------- stimulus generation ----------------
    function automatic void push_item(t_cmd c, int len, int ch);
        t_item it;
        it.cmd = c; it.len = len[19:0]; it.ch = ch[4:0];
        stim_q.push_back(it);
    endfunction

    function automatic int rand_len();
        int p;
        p = $urandom_range(99);
        if (p < 4) return $urandom_range(1, 20'hFFFFF);
        if (p < 8) return 0;
        return $urandom_range(1, 3);
    endfunction

    // Push one run, sometimes as two pieces of the same letter.
    function automatic void push_run(t_cmd c, int len, int ch);
        int a;
        if (len >= 2 && $urandom_range(99) < 20) begin
            a = $urandom_range(1, len - 1);
            push_item(c, a, ch);
            push_item(c, len - a, ch);
        end else begin
            push_item(c, len, ch);
        end
    endfunction

    function automatic void make_session();
        int m, letters, base, n, prev_ch;
        int plen [8];
        int pch [8];
        m       = ($urandom_range(99) < 8) ? 0 : $urandom_range(1, 7);
        letters = $urandom_range(2, 4);
        base    = $urandom_range(0, 26 - letters);
        prev_ch = -1;
        for (int i = 0; i < m; i++) begin
            do pch[i] = base + $urandom_range(0, letters - 1); while (pch[i] == prev_ch);
            prev_ch = pch[i];
            plen[i] = rand_len();
            if (plen[i] == 0) plen[i] = 1;
            push_run(CMD_PAT_RUN, plen[i], pch[i]);
            if ($urandom_range(99) < 5)
                push_item(CMD_TEXT_RUN, $urandom_range(1, 5), base);
            if ($urandom_range(99) < 5)
                push_item(CMD_PAT_RUN, 0, $urandom_range(0, 25));
        end
        if ($urandom_range(99) < 92) push_item(CMD_PAT_END, $urandom_range(0, 20'hFFFFF),
                                               $urandom_range(0, 25));
        if ($urandom_range(99) < 8) push_item(CMD_PAT_RUN, $urandom_range(1, 4), base);
        n = $urandom_range(3, 12);
        for (int s = 0; s < n; s++) begin
            if (m > 0 && $urandom_range(99) < 55) begin
                // Embed the pattern, edges possibly longer than needed.
                for (int i = 0; i < m; i++)
                    push_run(CMD_TEXT_RUN,
                             (i == 0 || i == m - 1) ? plen[i] + $urandom_range(0, 2)
                                                    : plen[i],
                             pch[i]);
            end else begin
                push_run(CMD_TEXT_RUN, rand_len(), base + $urandom_range(0, letters - 1));
            end
            if ($urandom_range(99) < 4) push_item(CMD_PAT_END, 1, base);
        end
        push_item(CMD_TEXT_END, $urandom_range(0, 20'hFFFFF), $urandom_range(0, 31));
    endfunction

    // Pattern with one run past the store size.
    function automatic void make_overflow_session();
        for (int i = 0; i <= MAX_PATTERN_RUNS; i++)
            push_item(CMD_PAT_RUN, 1, i % 2);
        push_item(CMD_PAT_END, 0, 0);
        push_item(CMD_TEXT_RUN, 1, 0);
        push_item(CMD_TEXT_RUN, 1, 1);
        push_item(CMD_TEXT_END, 0, 0);
    endfunction

    // ---------------- sender ----------------
    task automatic send_item(t_item it);
        bit     taken;
        t_count res;
        while (want_idle()) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_command    <= it.cmd;
        i_run_length <= it.len;
        i_run_char   <= it.ch;
        do begin
            @(negedge i_clk);
            taken = !o_stall;
            @(posedge i_clk);
        end while (!taken);
        n_items++;
        if (predict_count(it, res)) count_q.push_back(res);
    endtask

    // Directed part: reset behavior, extremes, each special case.
    t_row dir_rows [] = '{
        '{CMD_TEXT_END, 20'd0,       5'd0,  1'b1, '{48'd0, 1'b0, 1'b0}},
        '{CMD_PAT_RUN,  20'd0,       5'd0,  1'b0, '{default: '0}},
        '{CMD_TEXT_RUN, 20'd5,       5'd1,  1'b0, '{default: '0}},
        '{CMD_PAT_RUN,  20'd2,       5'd0,  1'b0, '{default: '0}},
        '{CMD_PAT_END,  20'd0,       5'd0,  1'b0, '{default: '0}},
        '{CMD_PAT_RUN,  20'd4,       5'd3,  1'b0, '{default: '0}},
        '{CMD_PAT_END,  20'd0,       5'd0,  1'b0, '{default: '0}},
        '{CMD_TEXT_RUN, 20'hFFFFF,   5'd0,  1'b0, '{default: '0}},
        '{CMD_TEXT_RUN, 20'd0,       5'd5,  1'b0, '{default: '0}},
        '{CMD_TEXT_RUN, 20'd1,       5'd0,  1'b0, '{default: '0}},
        '{CMD_TEXT_RUN, 20'd1,       5'd25, 1'b0, '{default: '0}},
        '{CMD_TEXT_END, 20'd0,       5'd0,  1'b1, '{48'd1048575, 1'b0, 1'b0}},
        '{CMD_PAT_RUN,  20'd1,       5'd25, 1'b0, '{default: '0}},
        '{CMD_PAT_RUN,  20'd2,       5'd16, 1'b0, '{default: '0}},
        '{CMD_PAT_END,  20'd0,       5'd0,  1'b0, '{default: '0}},
        '{CMD_TEXT_RUN, 20'd1,       5'd25, 1'b0, '{default: '0}},
        '{CMD_TEXT_RUN, 20'd2,       5'd16, 1'b0, '{default: '0}},
        '{CMD_TEXT_RUN, 20'd3,       5'd25, 1'b0, '{default: '0}},
        '{CMD_TEXT_RUN, 20'd1,       5'd16, 1'b0, '{default: '0}},
        '{CMD_TEXT_END, 20'd0,       5'd0,  1'b1, '{48'd1, 1'b0, 1'b0}},
        '{CMD_PAT_END,  20'd0,       5'd0,  1'b0, '{default: '0}},
        '{CMD_TEXT_RUN, 20'd4,       5'd10, 1'b0, '{default: '0}},
        '{CMD_TEXT_END, 20'hFFFFF,   5'd31, 1'b1, '{48'd0, 1'b0, 1'b0}}
    };

    initial begin
        t_item  it;
        i_rst_n = 1'b0; i_valid = 1'b0;
        i_command = '0; i_run_length = '0; i_run_char = '0;
        err_cnt = 0; n_items = 0; n_counts = 0; n_ovf = 0; n_nonzero = 0;
        idle_off = 0; hold_req = 0;
        clear_matcher();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r]) begin
            it.cmd = dir_rows[r].cmd; it.len = dir_rows[r].len; it.ch = dir_rows[r].ch;
            send_item(it);
            if (dir_rows[r].typed) begin
                // Check the block against the typed value; the model must agree too.
                if (count_q[$].count != dir_rows[r].want.count
                    || count_q[$].sat != dir_rows[r].want.sat
                    || count_q[$].ovf != dir_rows[r].want.ovf) begin
                    $error("directed row %0d: model count %0d differs from %0d",
                           r, count_q[$].count, dir_rows[r].want.count);
                    err_cnt++;
                end
                count_q[$] = dir_rows[r].want;
            end
        end
        // A short five-run case with a KMP restart in the text.
        push_item(CMD_PAT_RUN, 1, 1); push_item(CMD_PAT_RUN, 2, 2);
        push_item(CMD_PAT_RUN, 1, 1); push_item(CMD_PAT_RUN, 2, 2);
        push_item(CMD_PAT_RUN, 1, 3); push_item(CMD_PAT_END, 0, 0);
        push_item(CMD_TEXT_RUN, 1, 1); push_item(CMD_TEXT_RUN, 2, 2);
        push_item(CMD_TEXT_RUN, 1, 1); push_item(CMD_TEXT_RUN, 2, 2);
        push_item(CMD_TEXT_RUN, 1, 1); push_item(CMD_TEXT_RUN, 2, 2);
        push_item(CMD_TEXT_RUN, 1, 3); push_item(CMD_TEXT_END, 0, 0);
        make_overflow_session();
        while (stim_q.size() + n_items < TARGET_ITEMS) make_session();

        while (stim_q.size() > 0) begin
            it = stim_q.pop_front();
            if (n_items == 1500) idle_off = 1;
            if (n_items == 1700) idle_off = 0;
            if (n_items == 1300) hold_req = 1;
            send_item(it);
        end
        // Close whatever session is still open.
        it.cmd = CMD_TEXT_END; it.len = '0; it.ch = '0;
        send_item(it);
        i_valid <= 1'b0;

        while (count_q.size() > 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        $display("Sent %0d transfers, checked %0d counts (%0d nonzero, %0d overflowed).",
                 n_items, n_counts, n_nonzero, n_ovf);
        if (err_cnt == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // ---------------- receiver and checker ----------------
    initial begin
        bit     taken;
        int     hold_left;
        t_count want;
        hold_left = 0;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            taken = i_rst_n && o_valid && !i_stall;
            @(posedge i_clk);
            if (taken) begin
                if (count_q.size() == 0) begin
                    $error("count %0d reported with none due", o_match_count);
                    err_cnt++;
                end else begin
                    want = count_q.pop_front();
                    n_counts++;
                    if (want.count != 0) n_nonzero++;
                    if (want.ovf) n_ovf++;
                    if (o_match_count !== want.count) begin
                        $error("match_count: expected %0d, got %0d",
                               want.count, o_match_count);
                        err_cnt++;
                    end
                    if (o_count_saturated !== want.sat) begin
                        $error("count_saturated: expected %0b, got %0b",
                               want.sat, o_count_saturated);
                        err_cnt++;
                    end
                    if (o_pattern_overflow !== want.ovf) begin
                        $error("pattern_overflow: expected %0b, got %0b",
                               want.ovf, o_pattern_overflow);
                        err_cnt++;
                    end
                end
            end
            // Hold off the output for a long stretch once.
            if (hold_req && hold_left == 0) begin
                hold_req  = 0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= want_idle();
            end
        end
    end
endmodule

### sim.f
hw/rtl/rlpm_pkg.sv
hw/rtl/rlpm_ram.sv
hw/rtl/run_length_pattern_match_counter.sv
sim/run_length_pattern_match_counter_tb.sv
